>>> hdl/text_console_char_writer_top_macros.svh
// Assertion macros for the text console character writer checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_CHK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_CHK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Used by the controller, the datapath, the top level and the checker.
package tcw_pkg;

  localparam int OFF_W = 11;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  localparam int TAB_STOP = 4;

  localparam logic [7:0]  RESET_ATTR = 8'h0F;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // accept beat: update cursor, write or read a cell
    logic clear;  // clearing pass, one cell
    logic copy;   // scroll copy, one cell
    logic blank;  // blank bottom row, one cell
    logic load;   // load the result register
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic copy_last;
    logic blank_last;
    logic scroll;
    logic out_busy;
  } tcw_sts_t;

endpackage

>>> hdl/tcw_ctrl.sv
// Controller state machine for the text console character writer.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_COPY  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_BLANK = 6'b010000,
    S_RESP  = 6'b100000
  } tcw_state_t;

  tcw_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.scroll ? S_COPY : S_RESP;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) state_nxt = S_DRAIN;
      end
      // let the last copied cell land before blanking
      S_DRAIN: state_nxt = S_BLANK;
      S_BLANK: begin
        cmd.blank = 1'b1;
        if (sts.blank_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/tcw_dpath.sv
// Datapath for the text console character writer: cell memory, cursors,
// attribute register, cell counter and result register. Depends on tcw_pkg.
module tcw_dpath #(
  parameter int COLUMNS    = 80,
  parameter int ROWS_SHOWN = 25,
  parameter int SCREENS    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcw_pkg::tcw_cmd_t         cmd,
  output tcw_pkg::tcw_sts_t         sts,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_attribute,
  input  logic                      in_kind,
  input  logic [1:0]                in_screen_select,
  input  logic [7:0]                in_char_code,
  input  logic [4:0]                in_read_row,
  input  logic [6:0]                in_read_column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_cell_data,
  output logic [tcw_pkg::OFF_W-1:0] out_cursor_offset,
  output logic                      out_scrolled
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS_SHOWN * COLUMNS;
  localparam int TOTAL  = SCREENS * CELLS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS_SHOWN);
  localparam int SCR_W  = (SCREENS > 1) ? $clog2(SCREENS) : 1;

  function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned s,
                                                  input int unsigned r,
                                                  input int unsigned c);
    int unsigned a;
    a = s * CELLS + r * COLUMNS + c;
    return a[ADDR_W-1:0];
  endfunction

  // storage
  logic [15:0]       cell_mem_r [TOTAL];
  logic [15:0]       rd_data_r;
  logic [COL_W-1:0]  cur_col_r [SCREENS];
  logic [ROW_W-1:0]  cur_row_r [SCREENS];
  logic [7:0]        attr_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              copy_wr_vld_r;
  logic [ADDR_W-1:0] copy_wr_addr_r;

  // latched item
  logic [SCR_W-1:0]  scr_r;
  logic              scr_ok_r;
  logic              rd_hit_r;
  logic              scrolled_r;
  logic [ADDR_W-1:0] base_r;

  // result register
  logic                out_valid_r;
  logic [15:0]         out_cell_data_r;
  logic [OFF_W-1:0]    out_cursor_offset_r;
  logic                out_scrolled_r;

  // item decode
  logic [SCR_W-1:0]  in_idx;
  logic              in_scr_ok;
  logic              is_put;
  logic              rd_hit;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    step;
  logic [COL_W-1:0]  col_n;
  logic [ROW_W-1:0]  row_n;
  logic              nl;
  logic              row_last;
  logic              put_wr;
  logic [COL_W-1:0]  wr_col;
  logic [7:0]        wr_char;
  logic              do_put;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [15:0]       mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  logic [31:0]       off;

  assign cfg_ready = 1'b1;

  assign in_idx    = SCR_W'(in_screen_select);
  assign in_scr_ok = 32'(in_screen_select) < SCREENS;
  assign is_put    = (in_kind == KIND_PUT);
  assign rd_hit    = (in_kind == KIND_READ) && in_scr_ok &&
                     (32'(in_read_row) < ROWS_SHOWN) && (32'(in_read_column) < COLUMNS);
  assign col       = cur_col_r[in_idx];
  assign row       = cur_row_r[in_idx];
  assign col_ext   = {1'b0, col};
  assign row_last  = (row == ROW_W'(ROWS_SHOWN - 1));
  assign do_put    = cmd.exec && is_put && in_scr_ok;

  // next cursor for a put
  always_comb begin
    step    = col_ext;
    col_n   = col;
    nl      = 1'b0;
    put_wr  = 1'b0;
    wr_col  = col;
    wr_char = CH_BLANK;
    case (in_char_code)
      CH_BS: begin
        col_n  = (col == '0) ? '0 : col - 1'b1;
        put_wr = 1'b1;
        wr_col = col_n;
      end
      CH_TAB: begin
        step = (col_ext + (COL_W+1)'(TAB_STOP)) & ~((COL_W+1)'(TAB_STOP - 1));
        if (step >= COLUMNS) begin
          col_n = '0;
          nl    = 1'b1;
        end else begin
          col_n = step[COL_W-1:0];
        end
      end
      CH_CR: col_n = '0;
      CH_LF: begin
        col_n = '0;
        nl    = 1'b1;
      end
      default: begin
        if (in_char_code >= CH_PRINT_LO && in_char_code <= CH_PRINT_HI) begin
          put_wr  = 1'b1;
          wr_char = in_char_code;
          step    = col_ext + 1'b1;
          if (step >= COLUMNS) begin
            col_n = '0;
            nl    = 1'b1;
          end else begin
            col_n = step[COL_W-1:0];
          end
        end
      end
    endcase
    // at the last row the row holds and the screen scrolls
    row_n = (nl && !row_last) ? row + 1'b1 : row;
  end

  // status
  always_comb begin
    sts            = '0;
    sts.clear_last = (cnt_r == ADDR_W'(TOTAL - 1));
    sts.copy_last  = (cnt_r == ADDR_W'(CELLS - COLUMNS - 1));
    sts.blank_last = (cnt_r == ADDR_W'(CELLS - 1));
    sts.scroll     = is_put && in_scr_ok && nl && row_last;
    sts.out_busy   = out_valid_r && !out_ready;
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = RESET_CELL;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (do_put && put_wr) begin
      mem_we = 1'b1;
      mem_wa = cell_addr(32'(in_idx), 32'(row), 32'(wr_col));
      mem_wd = {attr_r, wr_char};
    end else if (copy_wr_vld_r) begin
      mem_we = 1'b1;
      mem_wa = copy_wr_addr_r;
      mem_wd = rd_data_r;
    end else if (cmd.blank) begin
      mem_we = 1'b1;
      mem_wa = base_r + cnt_r;
      mem_wd = {attr_r, CH_BLANK};
    end
    mem_re = cmd.copy || (cmd.exec && rd_hit);
    mem_ra = cmd.copy ? base_r + cnt_r + ADDR_W'(COLUMNS)
                      : cell_addr(32'(in_idx), 32'(in_read_row), 32'(in_read_column));
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem_r[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= cell_mem_r[mem_ra];
  end

  // cell counter shared by clearing, copy and blanking
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = sts.clear_last ? '0 : cnt_r + 1'b1;
    end else if (cmd.copy) begin
      cnt_nxt = sts.copy_last ? ADDR_W'(CELLS - COLUMNS) : cnt_r + 1'b1;
    end else if (cmd.blank) begin
      cnt_nxt = sts.blank_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      copy_wr_vld_r <= 1'b0;
      attr_r        <= RESET_ATTR;
      for (int i = 0; i < SCREENS; i++) begin
        cur_col_r[i] <= '0;
        cur_row_r[i] <= '0;
      end
    end else begin
      cnt_r         <= cnt_nxt;
      copy_wr_vld_r <= cmd.copy;
      if (cfg_valid && cfg_ready) attr_r <= cfg_attribute;
      for (int i = 0; i < SCREENS; i++) begin
        if (do_put && in_idx == SCR_W'(i)) begin
          cur_col_r[i] <= col_n;
          cur_row_r[i] <= row_n;
        end
      end
    end
  end

  // the copy write follows its read in the next cycle
  always_ff @(posedge clk) begin
    copy_wr_addr_r <= base_r + cnt_r;
    if (cmd.exec) begin
      scr_r      <= in_idx;
      scr_ok_r   <= in_scr_ok;
      rd_hit_r   <= rd_hit;
      scrolled_r <= sts.scroll;
      base_r     <= cell_addr(32'(in_idx), 32'd0, 32'd0);
    end
  end

  // result register
  always_comb begin
    off = 32'(cur_row_r[scr_r]) * COLUMNS + 32'(cur_col_r[scr_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_cell_data_r     <= rd_hit_r ? rd_data_r : '0;
      out_cursor_offset_r <= scr_ok_r ? off[OFF_W-1:0] : '0;
      out_scrolled_r      <= scrolled_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_cell_data_r;
  assign out_cursor_offset = out_cursor_offset_r;
  assign out_scrolled      = out_scrolled_r;

endmodule

>>> hdl/text_console_char_writer_top.sv
// Text console character writer: SCREENS screens of ROWS_SHOWN x COLUMNS cells
// in one simple dual-port cell memory (one write, one registered read per cycle).
// After reset a clearing pass writes every cell to a space with attribute 0x0F,
// one cell per cycle, with in_ready low; attribute writes on the cfg port are
// taken at any time. For a read, an ignored byte or a put that does not scroll,
// the accept beat updates the cursor and writes or reads the cell, and the
// result register is loaded once the previous result has been taken. A put
// that scrolls first does the row copy, a drain step and the bottom-row
// blanking, one cell per cycle through the memory port. The result register
// lets the next item be accepted while a result waits to be taken.
module text_console_char_writer_top #(
  parameter int COLUMNS    = 80,
  parameter int ROWS_SHOWN = 25,
  parameter int SCREENS    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_attribute,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [1:0]                in_screen_select,
  input  logic [7:0]                in_char_code,
  input  logic [4:0]                in_read_row,
  input  logic [6:0]                in_read_column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_cell_data,
  output logic [tcw_pkg::OFF_W-1:0] out_cursor_offset,
  output logic                      out_scrolled
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .COLUMNS    (COLUMNS),
    .ROWS_SHOWN (ROWS_SHOWN),
    .SCREENS    (SCREENS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_attribute     (cfg_attribute),
    .in_kind           (in_kind),
    .in_screen_select  (in_screen_select),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_data     (out_cell_data),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled)
  );

endmodule

>>> hdl/tcw_checker.sv
// Port-level checker for the text console character writer, bound to the top.
// Depends on tcw_pkg and text_console_char_writer_top_macros.svh.
`include "text_console_char_writer_top_macros.svh"

module tcw_checker #(
  parameter int COLUMNS    = 80,
  parameter int ROWS_SHOWN = 25
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [15:0]               out_cell_data,
  input logic [tcw_pkg::OFF_W-1:0] out_cursor_offset,
  input logic                      out_scrolled
);
  import tcw_pkg::*;

  // after a scroll the cursor sits at the start of the last row
  localparam logic [OFF_W-1:0] SCROLL_OFF = OFF_W'((ROWS_SHOWN - 1) * COLUMNS);

  `TCW_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cell_data), "stalled result beat changed")
  `TCW_CHK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input beat accepted back to back")
  `TCW_CHK_NOW(a_scroll_no_data, out_valid && out_scrolled, out_cell_data == 16'h0000, "scrolled beat carries cell data")
  `TCW_CHK_NOW(a_scroll_cursor, out_valid && out_scrolled, out_cursor_offset == SCROLL_OFF, "cursor not at last row after scroll")

endmodule

bind text_console_char_writer_top tcw_checker #(
  .COLUMNS    (COLUMNS),
  .ROWS_SHOWN (ROWS_SHOWN)
) u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_cell_data     (out_cell_data),
  .out_cursor_offset (out_cursor_offset),
  .out_scrolled      (out_scrolled)
);

>>> tb/text_console_char_writer_top_tb.sv
// Self-checking testbench for text_console_char_writer_top: shadows every screen and cursor
// in a scoreboard class and checks each result beat. Depends on tcw_pkg and the top level.
`timescale 1ns / 1ps

module text_console_char_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS_SHOWN  = 25;
  localparam int SCREENS     = 4;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASES      = 6;
  localparam int TIMEOUT_NS  = 20_000_000;

  typedef struct packed {
    logic       kind;
    logic [1:0] screen;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } console_req_t;

  typedef struct packed {
    logic [15:0]      cell_data;
    logic [OFF_W-1:0] offset;
    logic             scrolled;
  } console_rsp_t;

  class console_scoreboard;
    logic [15:0]  cells [SCREENS][ROWS_SHOWN][COLUMNS];
    logic [6:0]   cur_col [SCREENS];
    logic [4:0]   cur_row [SCREENS];
    logic [7:0]   attr;
    console_rsp_t pending [$];
    int           errors;

    function new();
      attr   = RESET_ATTR;
      errors = 0;
      for (int s = 0; s < SCREENS; s++) begin
        cur_col[s] = '0;
        cur_row[s] = '0;
        for (int r = 0; r < ROWS_SHOWN; r++)
          for (int c = 0; c < COLUMNS; c++)
            cells[s][r][c] = RESET_CELL;
      end
    endfunction

    // Step to the next row; scroll the screen up when past the bottom.
    function bit advance_line(int s);
      if (int'(cur_row[s]) + 1 < ROWS_SHOWN) begin
        cur_row[s] = cur_row[s] + 5'd1;
        return 1'b0;
      end
      for (int r = 0; r < ROWS_SHOWN - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          cells[s][r][c] = cells[s][r + 1][c];
      for (int c = 0; c < COLUMNS; c++)
        cells[s][ROWS_SHOWN - 1][c] = {attr, CH_BLANK};
      cur_row[s] = 5'(ROWS_SHOWN - 1);
      return 1'b1;
    endfunction

    function bit apply_put(int s, logic [7:0] ch);
      int col;
      bit rolled;
      col    = int'(cur_col[s]);
      rolled = 1'b0;
      if (ch == CH_BS) begin
        if (col != 0) col--;
        cur_col[s] = 7'(col);
        cells[s][cur_row[s]][col] = {attr, CH_BLANK};
        return 1'b0;
      end
      if (ch == CH_LF) begin
        cur_col[s] = '0;
        return advance_line(s);
      end
      if (ch == CH_TAB) begin
        col = (col + TAB_STOP) & ~(TAB_STOP - 1);
      end else if (ch == CH_CR) begin
        col = 0;
      end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
        cells[s][cur_row[s]][col] = {attr, ch};
        col++;
      end else begin
        return 1'b0;
      end
      if (col >= COLUMNS) begin
        col    = 0;
        rolled = advance_line(s);
      end
      cur_col[s] = 7'(col);
      return rolled;
    endfunction

    function void note_request(console_req_t q);
      console_rsp_t e;
      int s;
      s = int'(q.screen);
      e = '0;
      if (s < SCREENS) begin
        if (q.kind == KIND_PUT)
          e.scrolled = apply_put(s, q.ch);
        else if (int'(q.row) < ROWS_SHOWN && int'(q.col) < COLUMNS)
          e.cell_data = cells[s][q.row][q.col];
        e.offset = OFF_W'(int'(cur_row[s]) * COLUMNS + int'(cur_col[s]));
      end
      pending.push_back(e);
    endfunction

    function void check_response(console_rsp_t got);
      console_rsp_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding: cell_data %h", got.cell_data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cell_data != want.cell_data) begin
        $error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
        errors++;
      end
      if (got.offset != want.offset) begin
        $error("cursor_offset: expected %0d, got %0d", want.offset, got.offset);
        errors++;
      end
      if (got.scrolled != want.scrolled) begin
        $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_attribute;
  logic             in_valid;
  logic             in_ready;
  logic             in_kind;
  logic [1:0]       in_screen_select;
  logic [7:0]       in_char_code;
  logic [4:0]       in_read_row;
  logic [6:0]       in_read_column;
  logic             out_valid;
  logic             out_ready;
  logic [15:0]      out_cell_data;
  logic [OFF_W-1:0] out_cursor_offset;
  logic             out_scrolled;

  console_scoreboard board;
  bit                calm;
  int                sent;

  text_console_char_writer_top #(
    .COLUMNS    (COLUMNS),
    .ROWS_SHOWN (ROWS_SHOWN),
    .SCREENS    (SCREENS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_attribute     (cfg_attribute),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_screen_select  (in_screen_select),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_data     (out_cell_data),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check result beats and throttle the result side.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_response(console_rsp_t'({out_cell_data, out_cursor_offset, out_scrolled}));
      out_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_request(input console_req_t q);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= q.kind;
    in_screen_select <= q.screen;
    in_char_code     <= q.ch;
    in_read_row      <= q.row;
    in_read_column   <= q.col;
    do @(posedge clk); while (!in_ready);
    board.note_request(q);
    // dropped bytes do not count toward the phase
    if (q.kind == KIND_READ ||
        q.ch inside {CH_BS, CH_TAB, CH_LF, CH_CR, [CH_PRINT_LO:CH_PRINT_HI]})
      sent++;
  endtask

  task automatic put_byte(input int s, input logic [7:0] ch);
    console_req_t q;
    q.kind   = KIND_PUT;
    q.screen = 2'(s);
    q.ch     = ch;
    q.row    = 5'($urandom);
    q.col    = 7'($urandom);
    send_request(q);
  endtask

  task automatic read_cell(input int s, input int r, input int c);
    console_req_t q;
    q.kind   = KIND_READ;
    q.screen = 2'(s);
    q.ch     = 8'($urandom);
    q.row    = 5'(r);
    q.col    = 7'(c);
    send_request(q);
  endtask

  task automatic set_attribute(input logic [7:0] v);
    cfg_valid     <= 1'b1;
    cfg_attribute <= v;
    do @(posedge clk); while (!cfg_ready);
    board.attr = v;
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every outstanding result, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_traffic(input int n);
    int target;
    int s;
    int pick;
    console_req_t q;
    target = sent + n;
    while (sent < target) begin
      s    = ($urandom_range(99) < 50) ? 0 : int'($urandom_range(SCREENS - 1));
      pick = $urandom_range(99);
      if (pick < 40) begin
        // text line, now and then long enough to wrap
        repeat (($urandom_range(9) == 0) ? $urandom_range(90, 60) : $urandom_range(30, 1)) begin
          if ($urandom_range(99) < 88)
            put_byte(s, 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
          else
            case ($urandom_range(4))
              0: put_byte(s, CH_BS);
              1: put_byte(s, CH_TAB);
              2: put_byte(s, CH_CR);
              3: put_byte(s, CH_LF);
              default: put_byte(s, 8'($urandom));
            endcase
        end
      end else if (pick < 60) begin
        // read back near the cursor, anywhere on screen, and outside it
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(3))
            0: read_cell(s, board.cur_row[s],
                         (board.cur_col[s] == 0) ? 0 : int'(board.cur_col[s]) - 1);
            1: read_cell(s, board.cur_row[s], $urandom_range(COLUMNS - 1));
            2: read_cell(s, $urandom_range(ROWS_SHOWN - 1), $urandom_range(COLUMNS - 1));
            default: read_cell(s, $urandom_range(31), $urandom_range(127));
          endcase
        end
      end else if (pick < 70) begin
        // run down to the bottom row and scroll
        repeat ($urandom_range(30, 1))
          put_byte(s, ($urandom_range(3) == 0) ? CH_CR : CH_LF);
      end else if (pick < 78) begin
        repeat ($urandom_range(22, 1))
          put_byte(s, ($urandom_range(4) == 0) ?
                      8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)) : CH_TAB);
      end else if (pick < 88) begin
        repeat ($urandom_range(6, 1))
          put_byte(s, ($urandom_range(1) == 0) ?
                      8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)) : CH_BS);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          q = console_req_t'($bits(console_req_t)'($urandom));
          send_request(q);
        end
      end
    end
  endtask

  initial begin
    board            = new();
    calm             = 1'b0;
    sent             = 0;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_attribute    = '0;
    in_valid         = 1'b0;
    in_kind          = KIND_PUT;
    in_screen_select = '0;
    in_char_code     = '0;
    in_read_row      = '0;
    in_read_column   = '0;
    out_ready        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // cleared cells, both corners of the read window and just past it
    read_cell(0, 0, 0);
    read_cell(3, ROWS_SHOWN - 1, COLUMNS - 1);
    read_cell(2, ROWS_SHOWN, 0);
    read_cell(1, 0, COLUMNS);
    read_cell(0, 31, 127);
    // ends of the printable range, then bytes that are dropped
    put_byte(0, 8'h41);
    put_byte(0, CH_PRINT_LO);
    put_byte(0, CH_PRINT_HI);
    put_byte(0, 8'h00);
    put_byte(0, 8'h1F);
    put_byte(0, 8'h80);
    put_byte(0, 8'hFF);
    put_byte(0, CH_TAB);
    put_byte(0, CH_TAB);
    put_byte(0, CH_BS);
    // backspace at column 0 stays put but still blanks the cell
    put_byte(1, CH_BS);
    put_byte(0, CH_CR);
    put_byte(0, CH_LF);
    put_byte(3, CH_LF);
    read_cell(0, 0, 0);
    read_cell(0, 0, 2);
    read_cell(0, 0, 7);
    read_cell(1, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0)
        set_attribute(8'hFF);
      else if (p == 1)
        set_attribute(8'h00);
      else
        set_attribute(8'($urandom));
      calm = (p == 3);
      run_traffic(PHASE_ITEMS);
    end
    settle();

    if (board.errors == 0)
      $display("text_console_char_writer_top_tb passed");
    else
      $display("text_console_char_writer_top_tb failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("text_console_char_writer_top_tb failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_dpath.sv
hdl/text_console_char_writer_top.sv
hdl/tcw_checker.sv
tb/text_console_char_writer_top_tb.sv
